[rtl/dwd_pkg.sv]
// Shared types and constants for the deque with delete-by-value.
// Used by dwd_cell and deque_with_delete_by_value; depends on nothing.
package dwd_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int FILL_W   = $clog2(DEPTH + 1);
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OUT_W    = ((DATA_W + STATUS_W + COUNT_W + 7) / 8) * 8;
    localparam int PAD_W    = OUT_W - (DATA_W + STATUS_W + COUNT_W);

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT = 3'd0,
        KIND_PUSH_BACK  = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_DELETE     = 3'd4
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Per-cycle command broadcast to every cell.
    typedef struct packed {
        logic shift_in_front;   // push front: everyone takes the left neighbor
        logic shift_out_front;  // pop front: everyone takes the right neighbor
        logic load_tail;        // push back: cell at index fill takes the value
        logic del;              // delete: cells at or past the first match shift left
    } t_cell_cmd;

endpackage

[rtl/dwd_cell.sv]
// One storage cell of the deque chain: holds one entry and moves it as the command says.
// Depends on dwd_pkg.
module dwd_cell (
    input  logic                         i_clk,
    input  dwd_pkg::t_cell_cmd           i_cmd,
    input  logic [dwd_pkg::DATA_W-1:0]   i_value,
    input  logic [dwd_pkg::IDX_W-1:0]    i_index,
    input  logic [dwd_pkg::FILL_W-1:0]   i_fill,
    input  logic [dwd_pkg::DATA_W-1:0]   i_left_data,
    input  logic [dwd_pkg::DATA_W-1:0]   i_right_data,
    input  logic                         i_seen_in,
    output logic [dwd_pkg::DATA_W-1:0]   o_data,
    output logic [dwd_pkg::DATA_W-1:0]   o_tail_data,
    output logic                         o_seen_out
);

    logic [dwd_pkg::DATA_W-1:0] r_data;
    logic [dwd_pkg::DATA_W-1:0] n_data;
    logic [dwd_pkg::FILL_W-1:0] w_index;
    logic                       w_valid;
    logic                       w_match;

    assign w_index    = dwd_pkg::FILL_W'(i_index);
    assign w_valid    = w_index < i_fill;
    assign w_match    = w_valid && (r_data == i_value);
    assign o_seen_out = i_seen_in || w_match;
    assign o_data     = r_data;
    // Drive our entry onto the tail bus only when we are the last valid cell.
    assign o_tail_data = (w_index == (i_fill - dwd_pkg::FILL_W'(1))) ? r_data : '0;

    always_comb begin
        n_data = r_data;
        if (i_cmd.shift_in_front) begin
            n_data = i_left_data;
        end else if (i_cmd.shift_out_front) begin
            n_data = i_right_data;
        end else if (i_cmd.load_tail && (w_index == i_fill)) begin
            n_data = i_value;
        end else if (i_cmd.del && o_seen_out) begin
            n_data = i_right_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

[rtl/deque_with_delete_by_value.sv]
// Top level of the bounded deque with delete-by-value: control, fill count,
// output register and the row of dwd_cell entries. Depends on dwd_pkg, dwd_cell.
//
// The block keeps up to DEPTH unsigned 32-bit entries in a row of cells, the
// front in cell 0. Each input transfer carries an operation in tuser (push
// front, push back, pop front, pop back, delete value) and a value in tdata,
// and yields exactly one output transfer with the popped value, a status
// (ok, empty, not found, full) and the entry count afterwards. Every
// operation completes in the cycle it is accepted, so one item is taken per
// cycle as long as the output side keeps up; the result sits in a single
// output register and a new item is accepted whenever that register is empty
// or is being drained in the same cycle. The cycle time is set by the delete
// path: a 32-bit compare in every cell followed by the match chain that
// ripples from the front cell to the back cell. Push front shifts every cell
// one place back; pops from the front and deletes shift the cells from the
// removed entry onward one place forward. A push on a full queue and a pop
// on an empty one change nothing and report full or empty; a delete of an
// absent value reports not found. Kind codes 5 to 7 are ignored with status
// ok. Entry contents are not reset; only fill count and output valid are.
module deque_with_delete_by_value (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [dwd_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] value
    input  logic [dwd_pkg::KIND_W-1:0]   s_axis_tuser,  // [2:0] kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dwd_pkg::OUT_W-1:0]    m_axis_tdata   // [31:0] popped, [33:32] status,
                                                        // [38:34] count, [39] zero
);

    logic [dwd_pkg::FILL_W-1:0]  r_fill;
    logic [dwd_pkg::FILL_W-1:0]  n_fill;
    logic                        r_out_valid;
    logic [dwd_pkg::OUT_W-1:0]   r_out_data;

    logic                        w_accept;
    logic                        w_full;
    logic                        w_empty;
    dwd_pkg::t_kind              w_kind;
    dwd_pkg::t_status            w_status;
    dwd_pkg::t_cell_cmd          w_cmd;
    logic [dwd_pkg::DATA_W-1:0]  w_popped;
    logic [dwd_pkg::DATA_W-1:0]  w_tail;

    logic [dwd_pkg::DATA_W-1:0]  w_data      [dwd_pkg::DEPTH];
    logic [dwd_pkg::DATA_W-1:0]  w_tail_part [dwd_pkg::DEPTH];
    logic [dwd_pkg::DEPTH:0]     w_seen;

    // Take a new item whenever the output register is free or draining.
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign w_kind  = dwd_pkg::t_kind'(s_axis_tuser);
    assign w_full  = (r_fill == dwd_pkg::FILL_W'(dwd_pkg::DEPTH));
    assign w_empty = (r_fill == '0);

    // Match chain: enters the front cell clear, leaves the back cell set
    // if any valid entry equals the value.
    assign w_seen[0] = 1'b0;

    // Gather the last valid entry; at most one cell drives a nonzero word.
    always_comb begin
        w_tail = '0;
        for (int k = 0; k < dwd_pkg::DEPTH; k++) begin
            w_tail = w_tail | w_tail_part[k];
        end
    end

    // Decode the operation into cell commands, next fill and the result.
    always_comb begin
        w_cmd    = '0;
        n_fill   = r_fill;
        w_status = dwd_pkg::ST_OK;
        w_popped = '0;
        case (w_kind)
            dwd_pkg::KIND_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = dwd_pkg::ST_FULL;
                end else begin
                    w_cmd.shift_in_front = w_accept;
                    n_fill = r_fill + dwd_pkg::FILL_W'(1);
                end
            end
            dwd_pkg::KIND_PUSH_BACK: begin
                if (w_full) begin
                    w_status = dwd_pkg::ST_FULL;
                end else begin
                    w_cmd.load_tail = w_accept;
                    n_fill = r_fill + dwd_pkg::FILL_W'(1);
                end
            end
            dwd_pkg::KIND_POP_FRONT: begin
                if (w_empty) begin
                    w_status = dwd_pkg::ST_EMPTY;
                end else begin
                    w_cmd.shift_out_front = w_accept;
                    w_popped = w_data[0];
                    n_fill = r_fill - dwd_pkg::FILL_W'(1);
                end
            end
            dwd_pkg::KIND_POP_BACK: begin
                if (w_empty) begin
                    w_status = dwd_pkg::ST_EMPTY;
                end else begin
                    w_popped = w_tail;
                    n_fill = r_fill - dwd_pkg::FILL_W'(1);
                end
            end
            dwd_pkg::KIND_DELETE: begin
                if (w_seen[dwd_pkg::DEPTH]) begin
                    w_cmd.del = w_accept;
                    n_fill = r_fill - dwd_pkg::FILL_W'(1);
                end else begin
                    w_status = dwd_pkg::ST_NOTFOUND;
                end
            end
            default: begin
                // Unused kind: hold everything, report ok.
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < dwd_pkg::DEPTH; g++) begin : g_cell
            logic [dwd_pkg::DATA_W-1:0] w_left;
            logic [dwd_pkg::DATA_W-1:0] w_right;

            // The front cell takes the pushed value; the back cell refills
            // from itself, which only lands past the new fill.
            if (g == 0) begin : g_front
                assign w_left = s_axis_tdata;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == dwd_pkg::DEPTH - 1) begin : g_back
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end

            dwd_cell u_cell (
                .i_clk        (i_clk),
                .i_cmd        (w_cmd),
                .i_value      (s_axis_tdata),
                .i_index      (dwd_pkg::IDX_W'(g)),
                .i_fill       (r_fill),
                .i_left_data  (w_left),
                .i_right_data (w_right),
                .i_seen_in    (w_seen[g]),
                .o_data       (w_data[g]),
                .o_tail_data  (w_tail_part[g]),
                .o_seen_out   (w_seen[g+1])
            );
        end
    endgenerate

    // Fill count and output handshake state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: hold until the next accepted item.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= {{dwd_pkg::PAD_W{1'b0}},
                           dwd_pkg::COUNT_W'(n_fill),
                           w_status,
                           w_popped};
        end
    end

endmodule
